@@ rtl/q4sd_pkg.sv @@
// shared types and constants of the quad4 strain-displacement pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package q4sd_pkg;

    localparam int NODES   = 4;
    localparam int LANES   = 8;
    localparam int QBITS   = 32;
    localparam int COORD_W = 32;
    localparam int POS_W   = 16;
    localparam int DN_W    = 17;
    localparam int SUM_W   = 33;
    localparam int DIFF_W  = 34;
    localparam int PROD_W  = 51;
    localparam int RAW_W   = 52;
    localparam int JAC_W   = 32;
    localparam int TERM_W  = 49;
    localparam int NUM_SW  = 49;
    localparam int NUM_W   = 48;
    localparam int DET_W   = 64;

    localparam logic signed [DN_W-1:0]  ONE_Q14 = 17'sd16384;
    localparam logic signed [JAC_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [JAC_W-1:0] SAT_MIN = 32'sh8000_0000;
    localparam logic [COORD_W-1:0]      POS_ONE = 32'h0001_0000;
    localparam logic [COORD_W-1:0]      NEG_ONE = 32'hFFFF_0000;

    typedef enum logic [2:0] {
        REG_NODE1_X,
        REG_NODE1_Y,
        REG_NODE2_X,
        REG_NODE2_Y,
        REG_NODE3_X,
        REG_NODE3_Y,
        REG_NODE4_X,
        REG_NODE4_Y
    } cfg_reg_t;

    typedef struct packed {
        logic [NODES-1:0][COORD_W-1:0] x;
        logic [NODES-1:0][COORD_W-1:0] y;
    } node_t;

    localparam node_t NODE_RESET = '{
        x: {POS_ONE, NEG_ONE, NEG_ONE, POS_ONE},
        y: {NEG_ONE, NEG_ONE, POS_ONE, POS_ONE}
    };

    typedef struct packed {
        logic signed [POS_W-1:0]       pos_r;
        logic signed [POS_W-1:0]       pos_s;
        logic [NODES-1:0][COORD_W-1:0] disp_x;
        logic [NODES-1:0][COORD_W-1:0] disp_y;
    } point_t;

    typedef struct packed {
        logic signed [JAC_W-1:0] j00;
        logic signed [JAC_W-1:0] j01;
        logic signed [JAC_W-1:0] j10;
        logic signed [JAC_W-1:0] j11;
        logic signed [DN_W-1:0]  a;
        logic signed [DN_W-1:0]  b;
        logic signed [DN_W-1:0]  c;
        logic signed [DN_W-1:0]  d;
    } jac_t;

    typedef struct packed {
        logic [DET_W-1:0]            det_mag;
        logic [LANES-1:0][NUM_W-1:0] num_mag;
        logic [LANES-1:0]            neg;
        logic                        singular;
    } quo_t;

    typedef struct packed {
        logic [LANES-1:0][JAC_W-1:0] grad;
        logic                        singular;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/q4sd_jacobian.sv @@
// jacobian stages: current coordinates, shape derivative products, rounding
// depends on q4sd_pkg
`default_nettype none

module q4sd_jacobian
    import q4sd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_vld,
    input  point_t pt,
    input  node_t  node,
    output logic   out_vld,
    output jac_t   jac
);

    logic [2:0] vld_reg;

    logic signed [DN_W-1:0]   coef_next [4];
    logic signed [DN_W-1:0]   coef1_reg [4];
    logic signed [DN_W-1:0]   coef2_reg [4];
    logic signed [DIFF_W-1:0] dif_next [8];
    logic signed [DIFF_W-1:0] dif_reg [8];
    logic signed [PROD_W-1:0] prod_next [8];
    logic signed [PROD_W-1:0] prod_reg [8];
    logic signed [SUM_W-1:0]  xs [NODES];
    logic signed [SUM_W-1:0]  ys [NODES];
    logic signed [DN_W-1:0]   r_ext;
    logic signed [DN_W-1:0]   s_ext;
    jac_t                     jac_next;
    jac_t                     jac_reg;

    // round half up to Q.F, then clamp to 32 bits
    function automatic logic signed [JAC_W-1:0] rnd_sat(input logic signed [RAW_W-1:0] raw);
        logic signed [RAW_W-1:0]  t;
        logic signed [RAW_W-17:0] q;
        t = raw + (RAW_W'(1) <<< 15);
        q = t[RAW_W-1:16];
        if (q > (RAW_W-16)'(SAT_MAX)) begin
            return SAT_MAX;
        end
        else if (q < (RAW_W-16)'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return q[JAC_W-1:0];
    endfunction

    // stage 1: derivative factors and coordinate differences
    always_comb
    begin
        r_ext = DN_W'(pt.pos_r);
        s_ext = DN_W'(pt.pos_s);
        coef_next[0] = ONE_Q14 + s_ext;
        coef_next[1] = ONE_Q14 - s_ext;
        coef_next[2] = ONE_Q14 + r_ext;
        coef_next[3] = ONE_Q14 - r_ext;
        for (int k = 0; k < NODES; k++)
        begin
            xs[k] = SUM_W'($signed(node.x[k])) + SUM_W'($signed(pt.disp_x[k]));
            ys[k] = SUM_W'($signed(node.y[k])) + SUM_W'($signed(pt.disp_y[k]));
        end
        dif_next[0] = DIFF_W'(xs[0]) - DIFF_W'(xs[1]);
        dif_next[1] = DIFF_W'(xs[3]) - DIFF_W'(xs[2]);
        dif_next[2] = DIFF_W'(ys[0]) - DIFF_W'(ys[1]);
        dif_next[3] = DIFF_W'(ys[3]) - DIFF_W'(ys[2]);
        dif_next[4] = DIFF_W'(xs[0]) - DIFF_W'(xs[3]);
        dif_next[5] = DIFF_W'(xs[1]) - DIFF_W'(xs[2]);
        dif_next[6] = DIFF_W'(ys[0]) - DIFF_W'(ys[3]);
        dif_next[7] = DIFF_W'(ys[1]) - DIFF_W'(ys[2]);
    end

    // stage 2: eight products
    always_comb
    begin
        prod_next[0] = PROD_W'(coef1_reg[0]) * PROD_W'(dif_reg[0]);
        prod_next[1] = PROD_W'(coef1_reg[1]) * PROD_W'(dif_reg[1]);
        prod_next[2] = PROD_W'(coef1_reg[0]) * PROD_W'(dif_reg[2]);
        prod_next[3] = PROD_W'(coef1_reg[1]) * PROD_W'(dif_reg[3]);
        prod_next[4] = PROD_W'(coef1_reg[2]) * PROD_W'(dif_reg[4]);
        prod_next[5] = PROD_W'(coef1_reg[3]) * PROD_W'(dif_reg[5]);
        prod_next[6] = PROD_W'(coef1_reg[2]) * PROD_W'(dif_reg[6]);
        prod_next[7] = PROD_W'(coef1_reg[3]) * PROD_W'(dif_reg[7]);
    end

    // stage 3: sum pairs and round to Q.F
    always_comb
    begin
        jac_next.j00 = rnd_sat(RAW_W'(prod_reg[0]) + RAW_W'(prod_reg[1]));
        jac_next.j01 = rnd_sat(RAW_W'(prod_reg[2]) + RAW_W'(prod_reg[3]));
        jac_next.j10 = rnd_sat(RAW_W'(prod_reg[4]) + RAW_W'(prod_reg[5]));
        jac_next.j11 = rnd_sat(RAW_W'(prod_reg[6]) + RAW_W'(prod_reg[7]));
        jac_next.a   = coef2_reg[0];
        jac_next.b   = coef2_reg[1];
        jac_next.c   = coef2_reg[2];
        jac_next.d   = coef2_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef1_reg <= coef_next;
            coef2_reg <= coef1_reg;
            dif_reg   <= dif_next;
            prod_reg  <= prod_next;
            jac_reg   <= jac_next;
        end
    end

    assign out_vld = vld_reg[2];
    assign jac     = jac_reg;

endmodule

`default_nettype wire

@@ rtl/q4sd_numer.sv @@
// determinant and gradient numerators, then magnitudes and signs
// depends on q4sd_pkg
`default_nettype none

module q4sd_numer
    import q4sd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  jac_t jac,
    output logic out_vld,
    output quo_t quo
);

    logic [2:0] vld_reg;

    logic signed [DET_W-1:0]  pd_next [2];
    logic signed [DET_W-1:0]  pd_reg [2];
    logic signed [TERM_W-1:0] term_next [8];
    logic signed [TERM_W-1:0] term_reg [8];
    logic signed [DET_W-1:0]  det_next;
    logic signed [DET_W-1:0]  det_reg;
    logic signed [NUM_SW-1:0] num_next [LANES];
    logic signed [NUM_SW-1:0] num_reg [LANES];
    logic [NUM_SW-1:0]        mag_tmp;
    quo_t                     quo_next;
    quo_t                     quo_reg;

    // stage 1: products
    always_comb
    begin
        pd_next[0]   = DET_W'(jac.j00) * DET_W'(jac.j11);
        pd_next[1]   = DET_W'(jac.j01) * DET_W'(jac.j10);
        term_next[0] = TERM_W'(jac.j11) * TERM_W'(jac.a);
        term_next[1] = TERM_W'(jac.j11) * TERM_W'(jac.b);
        term_next[2] = TERM_W'(jac.j01) * TERM_W'(jac.c);
        term_next[3] = TERM_W'(jac.j01) * TERM_W'(jac.d);
        term_next[4] = TERM_W'(jac.j00) * TERM_W'(jac.c);
        term_next[5] = TERM_W'(jac.j00) * TERM_W'(jac.d);
        term_next[6] = TERM_W'(jac.j10) * TERM_W'(jac.a);
        term_next[7] = TERM_W'(jac.j10) * TERM_W'(jac.b);
    end

    // stage 2: determinant and per-node numerators with the node sign pattern
    always_comb
    begin
        det_next    = pd_reg[0] - pd_reg[1];
        num_next[0] = term_reg[0] - term_reg[2];
        num_next[1] = -term_reg[0] - term_reg[3];
        num_next[2] = term_reg[3] - term_reg[1];
        num_next[3] = term_reg[1] + term_reg[2];
        num_next[4] = term_reg[4] - term_reg[6];
        num_next[5] = term_reg[5] + term_reg[6];
        num_next[6] = term_reg[7] - term_reg[5];
        num_next[7] = -term_reg[4] - term_reg[7];
    end

    // stage 3: sign-magnitude split
    always_comb
    begin
        mag_tmp = '0;
        quo_next.det_mag  = det_reg[DET_W-1] ? (DET_W'(0) - det_reg) : det_reg;
        quo_next.singular = (det_reg == '0);
        for (int l = 0; l < LANES; l++)
        begin
            mag_tmp = num_reg[l][NUM_SW-1] ? (NUM_SW'(0) - num_reg[l]) : num_reg[l];
            quo_next.num_mag[l] = mag_tmp[NUM_W-1:0];
            quo_next.neg[l]     = num_reg[l][NUM_SW-1] ^ det_reg[DET_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg   <= pd_next;
            term_reg <= term_next;
            det_reg  <= det_next;
            num_reg  <= num_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_vld = vld_reg[2];
    assign quo     = quo_reg;

endmodule

`default_nettype wire

@@ rtl/q4sd_divider.sv @@
// eight-lane pipelined restoring divider, one quotient bit per stage,
// with round to nearest and saturation; depends on q4sd_pkg
`default_nettype none

module q4sd_divider
    import q4sd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  quo_t quo,
    output logic out_vld,
    output res_t res
);

    localparam int SH   = 2 * FRAC_BITS - 16;
    localparam int XW   = NUM_W + SH;
    localparam int TOPW = XW - QBITS;

    // lq holds the low dividend bits still to shift in, quotient bits fill from the right
    typedef struct packed {
        logic [DET_W-1:0] rem;
        logic [QBITS-1:0] lq;
        logic             ovf;
        logic             neg;
    } lane_t;

    lane_t            lane_next [0:QBITS][0:LANES-1];
    lane_t            lane_reg  [0:QBITS][0:LANES-1];
    logic [DET_W-1:0] dmag_reg  [0:QBITS];
    logic             sing_reg  [0:QBITS];
    logic [QBITS:0]   vld_reg;
    logic             res_vld_reg;
    res_t             res_next;
    res_t             res_reg;

    logic [XW-1:0]    xw;
    logic [TOPW-1:0]  top;
    logic [DET_W:0]   trial;
    logic [DET_W:0]   diff;
    logic [QBITS:0]   qf;
    logic             rnd;
    lane_t            fin;

    always_comb
    begin
        xw    = '0;
        top   = '0;
        trial = '0;
        diff  = '0;
        qf    = '0;
        rnd   = 1'b0;
        fin   = '0;
        res_next.singular = sing_reg[QBITS];
        for (int l = 0; l < LANES; l++)
        begin
            // alignment and overflow check on the upper dividend word
            xw  = XW'(quo.num_mag[l]) << SH;
            top = xw[XW-1:QBITS];
            lane_next[0][l].ovf = (DET_W'(top) >= quo.det_mag);
            lane_next[0][l].rem = lane_next[0][l].ovf ? '0 : DET_W'(top);
            lane_next[0][l].lq  = xw[QBITS-1:0];
            lane_next[0][l].neg = quo.neg[l];

            for (int k = 1; k <= QBITS; k++)
            begin
                trial = {lane_reg[k-1][l].rem, lane_reg[k-1][l].lq[QBITS-1]};
                diff  = trial - {1'b0, dmag_reg[k-1]};
                lane_next[k][l].ovf = lane_reg[k-1][l].ovf;
                lane_next[k][l].neg = lane_reg[k-1][l].neg;
                if (!diff[DET_W])
                begin
                    lane_next[k][l].rem = diff[DET_W-1:0];
                    lane_next[k][l].lq  = {lane_reg[k-1][l].lq[QBITS-2:0], 1'b1};
                end
                else
                begin
                    lane_next[k][l].rem = trial[DET_W-1:0];
                    lane_next[k][l].lq  = {lane_reg[k-1][l].lq[QBITS-2:0], 1'b0};
                end
            end

            // round half away from zero, then apply sign and clamp; a singular determinant gives zero
            fin = lane_reg[QBITS][l];
            rnd = ({fin.rem, 1'b0} >= {1'b0, dmag_reg[QBITS]});
            qf  = {1'b0, fin.lq} + (QBITS+1)'(rnd);
            if (sing_reg[QBITS])
            begin
                res_next.grad[l] = '0;
            end
            else if (fin.ovf || qf[QBITS] || qf[QBITS-1])
            begin
                res_next.grad[l] = fin.neg ? SAT_MIN : SAT_MAX;
            end
            else if (fin.neg)
            begin
                res_next.grad[l] = qf[QBITS-1:0] ^ '1;
                res_next.grad[l] = res_next.grad[l] + JAC_W'(1);
            end
            else
            begin
                res_next.grad[l] = qf[QBITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[QBITS-1:0], in_vld};
            res_vld_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= QBITS; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    lane_reg[k][l] <= lane_next[k][l];
                end
            end
            dmag_reg[0] <= quo.det_mag;
            sing_reg[0] <= quo.singular;
            for (int k = 1; k <= QBITS; k++)
            begin
                dmag_reg[k] <= dmag_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    assign out_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

`default_nettype wire

@@ rtl/quad4_strain_displacement.sv @@
// top level: node coordinate registers, the three pipeline sections, output skid stage
// depends on q4sd_pkg, q4sd_jacobian, q4sd_numer, q4sd_divider
`default_nettype none

// spatial shape-function gradients (the distinct entries of the B matrix) of a
// 4-node bilinear quad at one integration point per transfer. a point is taken
// every cycle while in_ready is high. the divider resolves one quotient bit per
// stage for 32 stages in eight parallel lanes (one per gradient), behind three
// jacobian stages and three determinant/numerator stages. the output register
// plus one skid entry let the pipeline keep taking points while a finished
// result waits; input ready drops only while the skid entry is full.
// node coordinates are written through cfg_we/cfg_index/cfg_wdata and must only
// change while no point is in flight. FRAC_BITS sets the fixed-point scale of
// coordinates and results (8 to 30). a zero determinant gives singular = 1 and
// all gradients zero.
module quad4_strain_displacement
    import q4sd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pos_r,
    input  logic signed [15:0] pos_s,
    input  logic signed [31:0] disp1_x,
    input  logic signed [31:0] disp1_y,
    input  logic signed [31:0] disp2_x,
    input  logic signed [31:0] disp2_y,
    input  logic signed [31:0] disp3_x,
    input  logic signed [31:0] disp3_y,
    input  logic signed [31:0] disp4_x,
    input  logic signed [31:0] disp4_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] grad1_x,
    output logic signed [31:0] grad2_x,
    output logic signed [31:0] grad3_x,
    output logic signed [31:0] grad4_x,
    output logic signed [31:0] grad1_y,
    output logic signed [31:0] grad2_y,
    output logic signed [31:0] grad3_y,
    output logic signed [31:0] grad4_y,
    output logic               singular
);

    // node coordinate registers
    node_t  node_reg;
    node_t  node_next;

    // pipeline links
    logic   en;
    point_t pt;
    logic   jac_vld;
    jac_t   jac;
    logic   quo_vld;
    quo_t   quo;
    logic   div_vld;
    res_t   div_res;

    // output register and skid entry
    res_t   out_reg;
    res_t   out_next;
    res_t   skid_reg;
    res_t   skid_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   skid_vld_reg;
    logic   skid_vld_next;

    // config writes: unused codes do not exist with a 3-bit index
    always_comb
    begin
        node_next = node_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NODE1_X: node_next.x[0] = cfg_wdata;
                REG_NODE1_Y: node_next.y[0] = cfg_wdata;
                REG_NODE2_X: node_next.x[1] = cfg_wdata;
                REG_NODE2_Y: node_next.y[1] = cfg_wdata;
                REG_NODE3_X: node_next.x[2] = cfg_wdata;
                REG_NODE3_Y: node_next.y[2] = cfg_wdata;
                REG_NODE4_X: node_next.x[3] = cfg_wdata;
                REG_NODE4_Y: node_next.y[3] = cfg_wdata;
                default:     node_next = node_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg <= NODE_RESET;
        end
        else
        begin
            node_reg <= node_next;
        end
    end

    // whole pipeline advances together; it only freezes while the skid entry holds a result
    assign en       = !skid_vld_reg;
    assign in_ready = en;

    assign pt.pos_r     = pos_r;
    assign pt.pos_s     = pos_s;
    assign pt.disp_x[0] = disp1_x;
    assign pt.disp_x[1] = disp2_x;
    assign pt.disp_x[2] = disp3_x;
    assign pt.disp_x[3] = disp4_x;
    assign pt.disp_y[0] = disp1_y;
    assign pt.disp_y[1] = disp2_y;
    assign pt.disp_y[2] = disp3_y;
    assign pt.disp_y[3] = disp4_y;

    q4sd_jacobian u_jacobian (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .pt      (pt),
        .node    (node_reg),
        .out_vld (jac_vld),
        .jac     (jac)
    );

    q4sd_numer u_numer (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (jac_vld),
        .jac     (jac),
        .out_vld (quo_vld),
        .quo     (quo)
    );

    q4sd_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (quo_vld),
        .quo     (quo),
        .out_vld (div_vld),
        .res     (div_res)
    );

    // output register with one skid entry behind it
    always_comb
    begin
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg)
        begin
            // pipeline is frozen; drain the skid entry on a transfer
            if (out_ready)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (div_vld)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_next     = div_res;
                skid_vld_next = 1'b1;
            end
            else
            begin
                out_next     = div_res;
                out_vld_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_vld_reg;
    assign grad1_x   = out_reg.grad[0];
    assign grad2_x   = out_reg.grad[1];
    assign grad3_x   = out_reg.grad[2];
    assign grad4_x   = out_reg.grad[3];
    assign grad1_y   = out_reg.grad[4];
    assign grad2_y   = out_reg.grad[5];
    assign grad3_y   = out_reg.grad[6];
    assign grad4_y   = out_reg.grad[7];
    assign singular  = out_reg.singular;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry full while output register empty");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.singular) |-> (out_reg.grad == '0))
        else $error("singular result with nonzero gradient");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !out_ready))
        else $error("skid entry filled without an output stall");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// self-checking testbench of quad4_strain_displacement: random and directed points
// checked against a built-in gradient predictor; depends on rtl/q4sd_pkg.sv and the rtl
`timescale 1ns / 100ps

module tb;
    import q4sd_pkg::*;

    // one integration point as it is driven onto the input channel
    typedef struct {
        logic signed [15:0] r;
        logic signed [15:0] s;
        logic signed [31:0] ux [4];
        logic signed [31:0] uy [4];
    } point_item_t;

    // the gradients expected for one point
    typedef struct {
        logic signed [31:0] gx [4];
        logic signed [31:0] gy [4];
        logic               sing;
    } grad_result_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] pos_r = '0;
    logic signed [15:0] pos_s = '0;
    logic signed [31:0] disp_x [4] = '{default: '0};
    logic signed [31:0] disp_y [4] = '{default: '0};
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] grad_x [4];
    logic signed [31:0] grad_y [4];
    logic               singular;

    // predictor copy of the node coordinate registers
    logic signed [31:0] node_coord [8];

    point_item_t  pending_points [$];
    grad_result_t expected_grads [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int error_count = 0;
    int points_sent = 0;
    int grads_seen = 0;
    int singular_seen = 0;
    int quiet_cycles = 0;

    quad4_strain_displacement #(.FRAC_BITS(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_r     (pos_r),
        .pos_s     (pos_s),
        .disp1_x   (disp_x[0]),
        .disp1_y   (disp_y[0]),
        .disp2_x   (disp_x[1]),
        .disp2_y   (disp_y[1]),
        .disp3_x   (disp_x[2]),
        .disp3_y   (disp_y[2]),
        .disp4_x   (disp_x[3]),
        .disp4_y   (disp_y[3]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad1_x   (grad_x[0]),
        .grad2_x   (grad_x[1]),
        .grad3_x   (grad_x[2]),
        .grad4_x   (grad_x[3]),
        .grad1_y   (grad_y[0]),
        .grad2_y   (grad_y[1]),
        .grad3_y   (grad_y[2]),
        .grad4_y   (grad_y[3]),
        .singular  (singular)
    );

    always #10 clk = ~clk;

    // jacobian entry: round half up to q15.16, then clamp to 32 bits
    function automatic longint jac_round(input longint raw);
        longint q;
        q = (raw + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647)
            return 64'sd2147483647;
        if (q < -64'sd2147483648)
            return -64'sd2147483648;
        return q;
    endfunction

    // num * 2^16 / det, magnitude rounded to nearest with ties away, then signed and clamped
    function automatic longint grad_quotient(input longint num, input longint det);
        logic [127:0] dividend;
        logic [127:0] divisor;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        neg = (num < 0) != (det < 0);
        if (num == 0)
            return 0;
        dividend = {64'b0, 64'(num < 0 ? -num : num)} << 16;
        divisor  = {64'b0, 64'(det < 0 ? -det : det)};
        quo = dividend / divisor;
        rem = dividend % divisor;
        if (rem >= divisor - rem)
            quo = quo + 1;
        if (neg)
            return (quo >= 128'h8000_0000) ? -64'sd2147483648 : -longint'(quo);
        return (quo >= 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(quo);
    endfunction

    // spatial gradients of the four shape functions at one point, current geometry
    function automatic grad_result_t predict_gradients(input point_item_t p);
        grad_result_t res;
        longint       x [4];
        longint       y [4];
        longint       dnr [4];
        longint       dns [4];
        longint       a, b, c, d;
        longint       j00, j01, j10, j11, det;
        a = 16384 + longint'(p.s);
        b = 16384 - longint'(p.s);
        c = 16384 + longint'(p.r);
        d = 16384 - longint'(p.r);
        for (int k = 0; k < 4; k++)
        begin
            x[k] = longint'(node_coord[2*k]) + longint'(p.ux[k]);
            y[k] = longint'(node_coord[2*k+1]) + longint'(p.uy[k]);
        end
        dnr = '{a, -a, -b, b};
        dns = '{c, d, -d, -c};
        j00 = jac_round(a * (x[0] - x[1]) + b * (x[3] - x[2]));
        j01 = jac_round(a * (y[0] - y[1]) + b * (y[3] - y[2]));
        j10 = jac_round(c * (x[0] - x[3]) + d * (x[1] - x[2]));
        j11 = jac_round(c * (y[0] - y[3]) + d * (y[1] - y[2]));
        det = j00 * j11 - j01 * j10;
        res.sing = (det == 0);
        for (int k = 0; k < 4; k++)
        begin
            res.gx[k] = '0;
            res.gy[k] = '0;
            if (det != 0)
            begin
                res.gx[k] = 32'(grad_quotient(j11 * dnr[k] - j01 * dns[k], det));
                res.gy[k] = 32'(grad_quotient(j00 * dns[k] - j10 * dnr[k], det));
            end
        end
        return res;
    endfunction

    // driver: a new point goes out only when the channel is free or the last one transferred
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                points_sent <= points_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    point_item_t p;
                    p = pending_points.pop_front();
                    // expectation is taken now; config never changes with points in flight
                    expected_grads.push_back(predict_gradients(p));
                    in_valid <= 1'b1;
                    pos_r <= p.r;
                    pos_s <= p.s;
                    for (int k = 0; k < 4; k++)
                    begin
                        disp_x[k] <= p.ux[k];
                        disp_y[k] <= p.uy[k];
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            if (out_valid && out_ready)
            begin
                grads_seen <= grads_seen + 1;
                if (singular)
                    singular_seen <= singular_seen + 1;
                if (expected_grads.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $realtime);
                    error_count <= error_count + 1;
                end
                else
                begin
                    grad_result_t e;
                    int           bad;
                    e = expected_grads.pop_front();
                    bad = 0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (grad_x[k] !== e.gx[k])
                        begin
                            $display("%0t: grad%0d_x expected %0d actual %0d",
                                     $realtime, k + 1, e.gx[k], grad_x[k]);
                            bad++;
                        end
                        if (grad_y[k] !== e.gy[k])
                        begin
                            $display("%0t: grad%0d_y expected %0d actual %0d",
                                     $realtime, k + 1, e.gy[k], grad_y[k]);
                            bad++;
                        end
                    end
                    if (singular !== e.sing)
                    begin
                        $display("%0t: singular expected %0b actual %0b",
                                 $realtime, e.sing, singular);
                        bad++;
                    end
                    error_count <= error_count + bad;
                end
            end
        end
    end

    // watchdog on cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // write all eight node registers on consecutive cycles, then drop the enable once
    task automatic load_nodes(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= v[i];
            node_coord[i] = v[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle once every point is out and every result has come back
    task automatic drain_pipeline();
        while (pending_points.size() > 0 || in_valid || expected_grads.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic point_item_t make_point(input int r, input int s, input int mode);
        point_item_t p;
        p.r = 16'(r);
        p.s = 16'(s);
        for (int k = 0; k < 4; k++)
        begin
            case (mode)
                0: begin p.ux[k] = '0; p.uy[k] = '0; end
                1: begin
                    p.ux[k] = int'($urandom_range(0, 40000)) - 20000;
                    p.uy[k] = int'($urandom_range(0, 40000)) - 20000;
                end
                default: begin p.ux[k] = $urandom; p.uy[k] = $urandom; end
            endcase
        end
        return p;
    endfunction

    initial
    begin
        logic [31:0] cfg [8];
        point_item_t p;
        int          pick;
        node_coord = '{32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000,
                       -32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 6; phase++)
        begin
            // idling pattern rotates: slow receiver, slow sender, none
            snd_idle_pct = (phase % 3 == 0) ? 14 : (phase % 3 == 1) ? 72 : 0;
            rcv_idle_pct = (phase % 3 == 0) ? 72 : (phase % 3 == 1) ? 14 : 0;
            for (int i = 0; i < 8; i++)
            begin
                case (phase)
                    0: cfg[i] = (i == 0 || i == 1 || i == 3 || i == 6) ? 32'h10000 : 32'hFFFF0000;
                    1: cfg[i] = $urandom_range(0, 6 << 16) - (3 << 16);
                    // extreme coordinates: full scale positive on every third register, negative elsewhere
                    2: cfg[i] = (i % 3 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    3: cfg[i] = $urandom;
                    // collapsed element: every point is singular unless displaced
                    4: cfg[i] = '0;
                    default: cfg[i] = $urandom_range(0, 15) - 8;
                endcase
            end
            load_nodes(cfg);

            if (phase == 0)
            begin
                // directed: corners and center of the natural square
                pending_points.push_back(make_point(0, 0, 0));
                pending_points.push_back(make_point(16384, 16384, 0));
                pending_points.push_back(make_point(-16384, -16384, 0));
                pending_points.push_back(make_point(16384, -16384, 0));
                pending_points.push_back(make_point(-16384, 16384, 0));
                // natural coordinates beyond one, used as given
                pending_points.push_back(make_point(32767, -32768, 0));
                pending_points.push_back(make_point(-32768, 32767, 1));
                // zero determinant by collapsing the deformed element onto a point
                p = make_point(4000, -4000, 0);
                for (int k = 0; k < 4; k++)
                begin
                    p.ux[k] = -node_coord[2*k];
                    p.uy[k] = -node_coord[2*k+1];
                end
                pending_points.push_back(p);
                // degenerate to a line: all y equal
                p = make_point(0, 0, 0);
                for (int k = 0; k < 4; k++)
                    p.uy[k] = -node_coord[2*k+1];
                pending_points.push_back(p);
                // displacement extremes drive jacobian and quotient saturation
                for (int e = 0; e < 4; e++)
                begin
                    p = make_point((e & 1) ? 16384 : -16384, (e & 2) ? 16384 : -16384, 0);
                    for (int k = 0; k < 4; k++)
                    begin
                        p.ux[k] = ((k + e) & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                        p.uy[k] = ((k + e) & 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    end
                    pending_points.push_back(p);
                end
                // tiny shear: one-unit displacements on nodes 1 and 2 of the undistorted square
                p = make_point(0, 0, 0);
                p.ux[0] = 32'sh0000_0001;
                p.uy[1] = -32'sh0000_0001;
                pending_points.push_back(p);
                pending_points.push_back(make_point(1, -1, 2));
                pending_points.push_back(make_point(-1, 1, 2));
            end

            for (int n = 0; n < 185; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    p = make_point(int'($urandom_range(0, 32768)) - 16384,
                                   int'($urandom_range(0, 32768)) - 16384, 1);
                else if (pick < 80)
                    p = make_point(int'($urandom_range(0, 32768)) - 16384,
                                   int'($urandom_range(0, 32768)) - 16384, 0);
                else
                    p = make_point($urandom, $urandom, 2);
                pending_points.push_back(p);
            end
            drain_pipeline();
        end

        $display("sent %0d points over six node settings, %0d results checked, %0d singular",
                 points_sent, grads_seen, singular_seen);
        $display("idling covered slow receiver, slow sender and full-rate streaming");
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
